[rtl/ise_pkg.sv]
// ise_pkg: shared types, constants and helpers for the integer stack engine.
// Used by ise_cell, ise_chain and integer_stack_engine; depends on nothing.
package ise_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int WORD_WIDTH  = 32;

  localparam int IDX_W   = $clog2(STACK_DEPTH);
  localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int FIELD_W = 32;
  localparam int OPC_W   = 3;
  localparam int PCNT_W  = 9;
  localparam int ECNT_W  = 9;
  localparam int CMP_W   = (CNT_W > PCNT_W) ? CNT_W : PCNT_W;

  typedef logic signed [WORD_WIDTH-1:0] word_t;

  typedef enum logic [OPC_W-1:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_POPN  = 3'd2,
    OP_CLEAR = 3'd3,
    OP_ODD   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_BADCOUNT = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POPN,
    S_ODD
  } state_e;

  typedef struct packed {
    logic [OPC_W-1:0]         op;
    logic signed [FIELD_W-1:0] value;
    logic [PCNT_W-1:0]        pop_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [FIELD_W-1:0] top_value;
    logic                     top_valid;
    logic signed [FIELD_W-1:0] second_value;
    logic                     second_valid;
    logic signed [FIELD_W-1:0] bottom_value;
    logic [ECNT_W-1:0]        entry_count;
  } out_item_t;

  typedef struct packed {
    logic shift_up;    // every cell not written takes the word of the cell below it; the last keeps its own
    logic shift_down;  // every cell not written takes the word of the cell above it; cell 0 takes wr_data
  } cell_ctrl_t;

  typedef struct packed {
    cell_ctrl_t move;
    logic       wr_en;
    logic [IDX_W-1:0] wr_idx;
    word_t      wr_data;
  } chain_ctrl_t;

  // Build a result from the post-operation view; absent entries read as zero.
  function automatic out_item_t make_result(status_e st, logic [CNT_W-1:0] cnt,
                                            word_t top_w, word_t sec_w,
                                            word_t bot_w);
    out_item_t r;
    r.status       = st;
    r.top_valid    = (cnt >= CNT_W'(1));
    r.second_valid = (cnt >= CNT_W'(2));
    r.top_value    = r.top_valid    ? FIELD_W'(top_w) : '0;
    r.second_value = r.second_valid ? FIELD_W'(sec_w) : '0;
    r.bottom_value = r.top_valid    ? FIELD_W'(bot_w) : '0;
    r.entry_count  = ECNT_W'(cnt);
    return r;
  endfunction

endpackage

[rtl/ise_cell.sv]
// ise_cell: one stack slot of the shift chain.
// Depends on ise_pkg for word_t and cell_ctrl_t.
module ise_cell import ise_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t move,
  input  logic       sel,
  input  word_t      wr_data,
  input  word_t      from_above,
  input  word_t      from_below,
  output word_t      q
);

  word_t word_r, word_nxt;

  always_comb begin
    word_nxt = word_r;
    if (sel) begin
      word_nxt = wr_data;
    end else if (move.shift_down) begin
      word_nxt = from_above;
    end else if (move.shift_up) begin
      word_nxt = from_below;
    end
  end

  // payload only: no reset
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign q = word_r;

endmodule

[rtl/ise_chain.sv]
// ise_chain: row of ise_cell slots, cell 0 holds the top of the stack.
// Depends on ise_pkg and ise_cell.
module ise_chain import ise_pkg::*; (
  input  logic        clk,
  input  chain_ctrl_t ctrl,
  output word_t       top_w,
  output word_t       second_w,
  output word_t       third_w
);

  word_t words [STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    word_t above, below;
    logic  sel;

    assign sel = ctrl.wr_en && (ctrl.wr_idx == IDX_W'(i));

    if (i == 0) begin : g_first
      assign above = ctrl.wr_data;
    end else begin : g_mid_a
      assign above = words[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_last
      assign below = words[i];
    end else begin : g_mid_b
      assign below = words[i+1];
    end

    ise_cell u_cell (
      .clk        (clk),
      .move       (ctrl.move),
      .sel        (sel),
      .wr_data    (ctrl.wr_data),
      .from_above (above),
      .from_below (below),
      .q          (words[i])
    );
  end

  assign top_w    = words[0];
  assign second_w = words[1];
  assign third_w  = (STACK_DEPTH > 2) ? words[(STACK_DEPTH > 2) ? 2 : 0] : '0;

endmodule

[rtl/integer_stack_engine.sv]
// integer_stack_engine: bounded LIFO of signed words built as a shift chain of cells.
// Push, pop, clear, unused and rejected ops finish at the accept edge, where the result is queued.
// Pop count of n and odd removal over n entries shift one entry a cycle, then queue the result.
// One single-step item per cycle while the two-deep result queue has room; it decouples the output.
// Reset (rst_n low, synchronous): entry count, controller state and result queue clear;
// the cells keep whatever they hold, as only slots below the entry count are ever read.
module integer_stack_engine import ise_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  state_e           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;     // entries still to shift or scan
  logic [CNT_W-1:0] kept_r, kept_nxt;   // even entries kept by odd removal
  word_t            bottom_r, bottom_nxt;

  chain_ctrl_t ctrl;
  word_t       top_w, second_w, third_w;
  word_t       push_w;

  logic      enq;
  out_item_t enq_item;

  // two-deep result queue
  out_item_t q_r [2];
  logic      wr_ptr_r, rd_ptr_r;
  logic [1:0] q_cnt_r, q_cnt_nxt;
  logic      deq;
  logic      in_fire;

  ise_chain u_chain (
    .clk      (clk),
    .ctrl     (ctrl),
    .top_w    (top_w),
    .second_w (second_w),
    .third_w  (third_w)
  );

  assign in_ready  = (state_r == S_IDLE) && (q_cnt_r != 2'd2);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (q_cnt_r != 2'd0);
  assign out_item  = q_r[rd_ptr_r];
  assign deq       = out_valid && out_ready;

  // keep the low WORD_WIDTH bits of the pushed field, sign-extended
  assign push_w = WORD_WIDTH'(in_item.value);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    rem_nxt    = rem_r;
    kept_nxt   = kept_r;
    bottom_nxt = bottom_r;
    ctrl       = '0;
    ctrl.wr_data = top_w;
    enq        = 1'b0;
    enq_item   = make_result(ST_OK, count_r, top_w, second_w, bottom_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          enq = 1'b1;
          case (in_item.op)
            OP_PUSH: begin
              if (count_r == CNT_W'(STACK_DEPTH)) begin
                enq_item = make_result(ST_FULL, count_r, top_w, second_w, bottom_r);
              end else begin
                ctrl.move.shift_down = 1'b1;
                ctrl.wr_en   = 1'b1;
                ctrl.wr_idx  = '0;
                ctrl.wr_data = push_w;
                count_nxt    = count_r + CNT_W'(1);
                if (count_r == '0) begin
                  bottom_nxt = push_w;
                end
                enq_item = make_result(ST_OK, count_nxt, push_w, top_w, bottom_nxt);
              end
            end
            OP_POP: begin
              if (count_r == '0) begin
                enq_item = make_result(ST_EMPTY, count_r, top_w, second_w, bottom_r);
              end else begin
                ctrl.move.shift_up = 1'b1;
                count_nxt = count_r - CNT_W'(1);
                enq_item  = make_result(ST_OK, count_nxt, second_w, third_w, bottom_r);
              end
            end
            OP_POPN: begin
              if (count_r == '0) begin
                enq_item = make_result(ST_EMPTY, count_r, top_w, second_w, bottom_r);
              end else if (in_item.pop_count == '0 ||
                           CMP_W'(in_item.pop_count) > CMP_W'(count_r)) begin
                enq_item = make_result(ST_BADCOUNT, count_r, top_w, second_w, bottom_r);
              end else begin
                // hold the result until the chain has shifted out every entry to be popped
                enq       = 1'b0;
                rem_nxt   = CNT_W'(in_item.pop_count);
                state_nxt = S_POPN;
              end
            end
            OP_CLEAR: begin
              count_nxt = '0;
              enq_item  = make_result(ST_OK, '0, top_w, second_w, bottom_r);
            end
            OP_ODD: begin
              enq       = 1'b0;
              rem_nxt   = count_r;
              kept_nxt  = '0;
              state_nxt = S_ODD;
            end
            default: begin
              // unused op codes: report the stack as it stands
              enq_item = make_result(ST_OK, count_r, top_w, second_w, bottom_r);
            end
          endcase
        end
      end

      S_POPN: begin
        if (rem_r != '0) begin
          // drop one entry off the top each cycle
          ctrl.move.shift_up = 1'b1;
          rem_nxt   = rem_r - CNT_W'(1);
          count_nxt = count_r - CNT_W'(1);
        end else begin
          enq       = 1'b1;
          enq_item  = make_result(ST_OK, count_r, top_w, second_w, bottom_r);
          state_nxt = S_IDLE;
        end
      end

      S_ODD: begin
        if (rem_r != '0) begin
          // take the top word, advance the chain, and append it behind the
          // kept region if it is even; kept words stay in their order
          ctrl.move.shift_up = 1'b1;
          rem_nxt = rem_r - CNT_W'(1);
          if (!top_w[0]) begin
            ctrl.wr_en   = 1'b1;
            ctrl.wr_idx  = IDX_W'(rem_r - CNT_W'(1) + kept_r);
            ctrl.wr_data = top_w;
            kept_nxt     = kept_r + CNT_W'(1);
            bottom_nxt   = top_w;
          end
        end else begin
          count_nxt = kept_r;
          enq       = 1'b1;
          enq_item  = make_result(ST_OK, kept_r, top_w, second_w, bottom_r);
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    q_cnt_nxt = q_cnt_r;
    if (enq && !deq) begin
      q_cnt_nxt = q_cnt_r + 2'd1;
    end else if (!enq && deq) begin
      q_cnt_nxt = q_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      rem_r    <= '0;
      kept_r   <= '0;
      q_cnt_r  <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rem_r   <= rem_nxt;
      kept_r  <= kept_nxt;
      q_cnt_r <= q_cnt_nxt;
      if (enq) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (deq) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    bottom_r <= bottom_nxt;
    if (enq) begin
      q_r[wr_ptr_r] <= enq_item;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STACK_DEPTH))
    else $error("entry count above stack depth");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= 2'd2)
    else $error("result queue overflow");

  a_full_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_item.op == OP_PUSH && count_r == CNT_W'(STACK_DEPTH))
      |=> (count_r == CNT_W'(STACK_DEPTH)))
    else $error("push onto full stack changed the entry count");

  a_popn_within: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POPN) |-> (rem_r <= count_r))
    else $error("pop count would run past the bottom");

  a_odd_no_enq_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ODD && rem_r != '0) |-> !enq)
    else $error("result queued while odd removal is still scanning");

endmodule

[sim/integer_stack_engine_tb.sv]
// integer_stack_engine_tb: self-checking testbench for the integer stack engine.
// Depends on ise_pkg (item structs, op and status codes, sizes) and integer_stack_engine.
// Keeps its own stack and checks every result, field by field, in arrival order.
module integer_stack_engine_tb;
  import ise_pkg::*;

  // Cycles with no item moving on either side before the run is declared hung.
  // The slowest legal step is odd removal over a full stack plus a long
  // receiver stall, so this leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int HOLD_CYCLES    = 80;
  localparam int RANDOM_ITEMS   = 330;
  localparam int PCNT_MAX       = (1 << PCNT_W) - 1;

  // Op codes outside the defined set; the block must ignore them.
  localparam logic [OPC_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OPC_W-1:0] OP_SPARE_HI = 3'd7;

  localparam word_t WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // Shadow stack: index 0 is the bottom, held_count entries are live.
  word_t     held_words [STACK_DEPTH];
  int        held_count    = 0;
  out_item_t expected_results [$];

  int error_count   = 0;
  int results_seen  = 0;
  int sent_items    = 0;
  int modeled_items = 0;
  int idle_cycles   = 0;

  // Idle rates in percent for each side, changed per phase.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // Long receiver stalls: asked for by a test, taken up by the receiver.
  int hold_asked    = 0;
  int hold_taken    = 0;
  int hold_left     = 0;

  integer_stack_engine u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  // Apply one op to the shadow stack and build the result it must produce.
  function automatic out_item_t predict_stack_op(in_item_t it);
    out_item_t r;
    status_e   st;
    int        kept;
    st = ST_OK;
    case (it.op)
      OP_PUSH: begin
        if (held_count >= STACK_DEPTH) begin
          st = ST_FULL;
        end else begin
          held_words[held_count] = word_t'(it.value);
          held_count++;
        end
      end
      OP_POP: begin
        if (held_count == 0) st = ST_EMPTY;
        else held_count--;
      end
      OP_POPN: begin
        if (held_count == 0) st = ST_EMPTY;
        else if (it.pop_count == 0 || int'(it.pop_count) > held_count) st = ST_BADCOUNT;
        else held_count -= int'(it.pop_count);
      end
      OP_CLEAR: held_count = 0;
      OP_ODD: begin
        // Compact the even words toward the bottom, keeping their order.
        kept = 0;
        for (int i = 0; i < held_count; i++) begin
          if (held_words[i][0] == 1'b0) begin
            held_words[kept] = held_words[i];
            kept++;
          end
        end
        held_count = kept;
      end
      default: ;  // spare codes leave the stack alone
    endcase
    r = '0;
    r.status = st;
    if (held_count >= 1) begin
      r.top_valid    = 1'b1;
      r.top_value    = FIELD_W'(held_words[held_count-1]);
      r.bottom_value = FIELD_W'(held_words[0]);
    end
    if (held_count >= 2) begin
      r.second_valid = 1'b1;
      r.second_value = FIELD_W'(held_words[held_count-2]);
    end
    r.entry_count = ECNT_W'(held_count);
    return r;
  endfunction

  // Report one field mismatch on one line and count it.
  task automatic check_field(string name, logic [FIELD_W-1:0] got, logic [FIELD_W-1:0] want);
    if (got !== want) begin
      error_count++;
      $display("mismatch in result %0d: %s got %0h, want %0h", results_seen, name, got, want);
    end
  endtask

  // Monitor: model each accepted item first, then check the result leaving
  // at the same edge, so ordering inside the step never matters. Also run
  // the watchdog here, since this block sees both handshakes.
  always @(posedge clk) begin
    logic      took_in;
    logic      took_out;
    out_item_t want;
    took_in  = in_valid && in_ready;
    took_out = out_valid && out_ready;
    if (rst_n) begin
      if (took_in) begin
        expected_results.push_back(predict_stack_op(in_item));
        modeled_items++;
      end
      if (took_out) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          error_count++;
          $display("result %0d arrived with nothing expected", results_seen);
        end else begin
          want = expected_results.pop_front();
          check_field("status",       FIELD_W'(out_item.status),       FIELD_W'(want.status));
          check_field("top_value",    out_item.top_value,              want.top_value);
          check_field("top_valid",    FIELD_W'(out_item.top_valid),    FIELD_W'(want.top_valid));
          check_field("second_value", out_item.second_value,           want.second_value);
          check_field("second_valid", FIELD_W'(out_item.second_valid),
                      FIELD_W'(want.second_valid));
          check_field("bottom_value", out_item.bottom_value,           want.bottom_value);
          check_field("entry_count",  FIELD_W'(out_item.entry_count),
                      FIELD_W'(want.entry_count));
        end
      end
      if (took_in || took_out) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Receiver: drop ready at random, or hold it low for a long stretch when
  // a test asks, counting the stretch down here.
  always @(posedge clk) begin
    if (hold_taken != hold_asked) begin
      hold_taken = hold_asked;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Offer one item, idling first at the current rate, and return once it is
  // accepted and the monitor has folded it into the shadow stack. Valid is
  // left high so a following item goes out back to back.
  task automatic send_op(in_item_t it);
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sent_items++;
    wait (modeled_items == sent_items);
  endtask

  function automatic in_item_t make_op(logic [OPC_W-1:0] op, word_t value = '0, int count = 0);
    in_item_t it;
    it.op        = op;
    it.value     = FIELD_W'(value);
    it.pop_count = PCNT_W'(count);
    return it;
  endfunction

  // Mix of full-range words, small words around zero, extremes and evens.
  function automatic word_t pick_push_value();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return word_t'($urandom);
    if (sel < 8) return word_t'($signed($urandom_range(0, 16)) - 8);
    if (sel == 8) return $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
    return word_t'($urandom) & ~word_t'(1);
  endfunction

  // Random op weighted toward pushes so the stack builds up; unused fields
  // carry random noise. Pop counts are mostly legal, some zero or too large.
  function automatic in_item_t pick_random_op();
    in_item_t    it;
    int unsigned sel;
    int          span;
    it.op        = OP_PUSH;
    it.value     = $urandom;
    it.pop_count = PCNT_W'($urandom_range(0, PCNT_MAX));
    sel = $urandom_range(0, 99);
    if (sel < 58) begin
      it.value = FIELD_W'(pick_push_value());
    end else if (sel < 72) begin
      it.op = OP_POP;
    end else if (sel < 84) begin
      it.op = OP_POPN;
      span  = (held_count > 8) ? 8 : ((held_count > 0) ? held_count : 1);
      case ($urandom_range(0, 9))
        0:       it.pop_count = '0;
        1:       ;  // keep the raw random count
        2:       it.pop_count = PCNT_W'(held_count + 1);
        3:       it.pop_count = PCNT_W'(held_count);
        default: it.pop_count = PCNT_W'($urandom_range(1, span));
      endcase
    end else if (sel < 86) begin
      it.op = OP_CLEAR;
    end else if (sel < 95) begin
      it.op = OP_ODD;
    end else begin
      it.op = OPC_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    end
    return it;
  endfunction

  // Every op but push against an empty stack, spare codes included.
  task automatic test_empty_stack();
    send_op(make_op(OP_POP));
    send_op(make_op(OP_POPN, '0, 1));
    send_op(make_op(OP_POPN, '0, 0));
    send_op(make_op(OP_CLEAR));
    send_op(make_op(OP_ODD));
    for (int c = OP_SPARE_LO; c <= OP_SPARE_HI; c++) send_op(make_op(c[OPC_W-1:0]));
  endtask

  // Extreme words, negative odd and even words, a spare code, bad and legal
  // pop counts, odd removal on a mixed stack, then clear, push and pop.
  task automatic test_word_extremes();
    send_op(make_op(OP_PUSH, WORD_MIN));
    send_op(make_op(OP_PUSH, WORD_MAX));
    send_op(make_op(OP_PUSH, -1));
    send_op(make_op(OP_PUSH, 0));
    send_op(make_op(OP_PUSH, -3));
    send_op(make_op(OP_PUSH, -4));
    send_op(make_op(OP_PUSH, 1));
    send_op(make_op(OP_SPARE_HI, WORD_MAX, PCNT_MAX));
    send_op(make_op(OP_POPN, '0, 0));
    send_op(make_op(OP_POPN, '0, PCNT_MAX));
    send_op(make_op(OP_POPN, '0, held_count + 1));
    send_op(make_op(OP_POPN, '0, 2));
    send_op(make_op(OP_POP, WORD_MAX));
    send_op(make_op(OP_ODD));
    send_op(make_op(OP_CLEAR));
    send_op(make_op(OP_PUSH, WORD_MAX));
    send_op(make_op(OP_POP));
  endtask

  // Fill to capacity, push past it, ask to pop one more than the depth, then odd removal
  // across the full stack, a pop of exactly everything that is left and a full-depth pop.
  task automatic test_full_stack();
    send_op(make_op(OP_CLEAR));
    repeat (STACK_DEPTH) send_op(make_op(OP_PUSH, pick_push_value()));
    repeat (2) send_op(make_op(OP_PUSH, pick_push_value()));
    send_op(make_op(OP_POPN, '0, STACK_DEPTH + 1));
    send_op(make_op(OP_ODD));
    send_op(make_op(OP_POPN, '0, held_count));
    send_op(make_op(OP_POPN, '0, STACK_DEPTH));
  endtask

  task automatic test_random_ops(int count);
    repeat (count) send_op(pick_random_op());
  endtask

  // Hold the receiver off for a long stretch while items keep coming, so
  // the result queue fills and the input stalls.
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_asked++;
    repeat (24) send_op(pick_random_op());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Phase one: sender idles a little, receiver a lot.
    send_idle_pct = 22;
    recv_idle_pct = 71;
    test_empty_stack();
    test_word_extremes();
    test_full_stack();
    test_random_ops(RANDOM_ITEMS);

    // Phase two: the other way round.
    send_idle_pct = 71;
    recv_idle_pct = 22;
    test_random_ops(RANDOM_ITEMS);

    test_output_stall();

    // Phase three: neither side idles.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_ops(RANDOM_ITEMS);

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

[integer_stack_engine.f]
rtl/ise_pkg.sv
rtl/ise_cell.sv
rtl/ise_chain.sv
rtl/integer_stack_engine.sv
sim/integer_stack_engine_tb.sv
